>>> rtl/bulk_vector_record_parser_macros.svh
// Assertion macros for the bulk vector record parser.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef BULK_VECTOR_RECORD_PARSER_MACROS_SVH
`define BULK_VECTOR_RECORD_PARSER_MACROS_SVH

// same-cycle implication
`define BVRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BVRP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bvrp_pkg.sv
// Shared types and constants of the bulk vector record parser.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bvrp_pkg;

  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned BATCH_CAP_DEF = 1048576;
  localparam int unsigned LENGTH_BITS_DEF = 40;
  localparam int unsigned QDEPTH = 4;

  // body tag, byte 0 first
  localparam logic [7:0] TAG_BYTES [4] = '{8'h56, 8'h46, 8'h42, 8'h31};

  localparam logic [15:0] EXP_DIM_RST = 16'd1;
  localparam logic [20:0] BATCH_LIM_RST = 21'd1024;
  localparam logic [63:0] RSV_ID_RST = '1;

  typedef enum logic [1:0] {
    CFG_EXPECTED_DIM = 2'd0,
    CFG_BATCH_LIMIT  = 2'd1,
    CFG_RESERVED_ID  = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_ID     = 2'd0,
    KIND_FLOAT  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_HDR  = 3'd1,
    ST_DIM      = 3'd2,
    ST_LIMIT    = 3'd3,
    ST_LENGTH   = 3'd4,
    ST_RESERVED = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] word;
    logic [35:0] position;
    logic [2:0]  status;
    logic [19:0] bad_record;
    logic [63:0] record_count;
    logic        run_end;
  } out_t;

  // everything one byte produces: an optional data result and an optional status
  typedef struct packed {
    logic        data_v;
    kind_e       kind;
    logic [63:0] word;
    logic [35:0] position;
    logic        fin_v;
    status_e     status;
    logic [19:0] bad_record;
    logic [63:0] record_count;
  } entry_t;

  typedef struct packed {
    logic [15:0] expected_dim;
    logic [20:0] batch_limit;
    logic [63:0] reserved_id;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/bvrp_front.sv
// Front end: parses the byte stream, checks the header, assembles words.
// Depends on bvrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bvrp_front #(
  parameter int unsigned BATCH_CAP   = bvrp_pkg::BATCH_CAP_DEF,
  parameter int unsigned LENGTH_BITS = bvrp_pkg::LENGTH_BITS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire bvrp_pkg::cfg_t  cfg_i,
  input  wire logic            accept_i,
  input  wire bvrp_pkg::in_t   in_i,
  output logic                 push_o,
  output bvrp_pkg::entry_t     entry_o
);

  localparam int unsigned LB = LENGTH_BITS;
  localparam int unsigned CW = $clog2(BATCH_CAP + 1);
  localparam int unsigned EW = CW + 4;
  localparam logic [LB-1:0] CNT_MAX = '1;
  localparam logic [63:0] CNT_MAX64 = 64'(CNT_MAX);

  logic [LB-1:0]   cnt_q, cnt_d;
  logic            magic_ok_q, magic_ok_d;
  logic [31:0]     dim_q, dim_d;
  logic [63:0]     count_q, count_d;
  logic [LB-1:0]   exp_len_q, exp_len_d;
  logic [EW-1:0]   ids_end_q, ids_end_d;
  logic [63:0]     asm_q, asm_d;
  bvrp_pkg::status_e perr_q, perr_d;
  logic [19:0]     bad_q, bad_d;

  logic [LB-1:0]   pos;
  logic [7:0]      b;
  logic            hdr_err;
  logic [CW-1:0]   cnt_field;
  logic [CW+15:0]  prod;
  logic [63:0]     len64;
  logic [LB-1:0]   id_off, fl_off;
  logic            data_v;
  bvrp_pkg::kind_e data_kind;
  logic [63:0]     data_word;
  logic [35:0]     data_pos;
  bvrp_pkg::status_e fin_st;

  assign pos = cnt_q;
  assign b = in_i.byte_value;
  assign hdr_err = (perr_q == bvrp_pkg::ST_BAD_HDR) || (perr_q == bvrp_pkg::ST_DIM) ||
                   (perr_q == bvrp_pkg::ST_LIMIT);

  assign cnt_field = count_d[CW-1:0];
  assign prod = (CW + 16)'(cnt_field) * (CW + 16)'(cfg_i.expected_dim);
  assign len64 = 64'(bvrp_pkg::HEADER_BYTES) + (64'(cnt_field) << 3) + (64'(prod) << 2);
  assign id_off = pos - LB'(bvrp_pkg::HEADER_BYTES);
  assign fl_off = pos - LB'(ids_end_q);

  always_comb begin
    magic_ok_d = magic_ok_q;
    dim_d      = dim_q;
    count_d    = count_q;
    exp_len_d  = exp_len_q;
    ids_end_d  = ids_end_q;
    asm_d      = asm_q;
    perr_d     = perr_q;
    bad_d      = bad_q;
    data_v     = 1'b0;
    data_kind  = bvrp_pkg::KIND_ID;
    data_word  = asm_q;
    data_pos   = '0;

    if (pos < LB'(4)) begin
      if (b != bvrp_pkg::TAG_BYTES[pos[1:0]]) magic_ok_d = 1'b0;
    end else if (pos < LB'(8)) begin
      dim_d[{pos[1:0], 3'b000} +: 8] = b;
    end else if (pos < LB'(bvrp_pkg::HEADER_BYTES)) begin
      count_d[{pos[2:0], 3'b000} +: 8] = b;
    end

    if (pos == LB'(bvrp_pkg::HEADER_BYTES - 1)) begin
      if (!magic_ok_d) begin
        perr_d = bvrp_pkg::ST_BAD_HDR;
      end else if (dim_d != 32'(cfg_i.expected_dim)) begin
        perr_d = bvrp_pkg::ST_DIM;
      end else if (count_d > 64'(cfg_i.batch_limit) || count_d > 64'(BATCH_CAP)) begin
        perr_d = bvrp_pkg::ST_LIMIT;
      end else begin
        exp_len_d = (len64 > CNT_MAX64) ? CNT_MAX : len64[LB-1:0];
        ids_end_d = EW'(bvrp_pkg::HEADER_BYTES) + (EW'(cnt_field) << 3);
      end
    end else if (pos >= LB'(bvrp_pkg::HEADER_BYTES) && !hdr_err) begin
      if (pos >= exp_len_q) begin
        perr_d = bvrp_pkg::ST_LENGTH;
      end else if (perr_q == bvrp_pkg::ST_OK) begin
        if (64'(pos) < 64'(ids_end_q)) begin
          if (pos[2:0] == 3'd0) asm_d = 64'(b);
          else asm_d[{pos[2:0], 3'b000} +: 8] = b;
          if (pos[2:0] == 3'd7) begin
            if (asm_d == cfg_i.reserved_id) begin
              perr_d = bvrp_pkg::ST_RESERVED;
              bad_d  = 20'(id_off >> 3);
            end else begin
              data_v    = 1'b1;
              data_kind = bvrp_pkg::KIND_ID;
              data_word = asm_d;
              data_pos  = 36'(id_off >> 3);
            end
          end
        end else begin
          if (pos[1:0] == 2'd0) asm_d = 64'(b);
          else asm_d[{1'b0, pos[1:0], 3'b000} +: 8] = b;
          if (pos[1:0] == 2'd3) begin
            data_v    = 1'b1;
            data_kind = bvrp_pkg::KIND_FLOAT;
            data_word = {32'd0, asm_d[31:0]};
            data_pos  = 36'(fl_off >> 2);
          end
        end
      end
    end

    cnt_d = (cnt_q != CNT_MAX) ? cnt_q + LB'(1) : cnt_q;

    if (pos < LB'(bvrp_pkg::HEADER_BYTES - 1)) begin
      fin_st = bvrp_pkg::ST_BAD_HDR;
    end else if (perr_d == bvrp_pkg::ST_BAD_HDR || perr_d == bvrp_pkg::ST_DIM ||
                 perr_d == bvrp_pkg::ST_LIMIT) begin
      fin_st = perr_d;
    end else if (pos >= CNT_MAX - LB'(1) ||
                 {1'b0, exp_len_d} != ({1'b0, pos} + (LB + 1)'(1))) begin
      fin_st = bvrp_pkg::ST_LENGTH;
    end else if (perr_d == bvrp_pkg::ST_RESERVED) begin
      fin_st = bvrp_pkg::ST_RESERVED;
    end else begin
      fin_st = bvrp_pkg::ST_OK;
    end
  end

  assign push_o = accept_i && (data_v || in_i.final_byte);

  always_comb begin
    entry_o.data_v       = data_v;
    entry_o.kind         = data_kind;
    entry_o.word         = data_word;
    entry_o.position     = data_pos;
    entry_o.fin_v        = in_i.final_byte;
    entry_o.status       = fin_st;
    entry_o.bad_record   = (fin_st == bvrp_pkg::ST_RESERVED) ? bad_d : 20'd0;
    entry_o.record_count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      magic_ok_q <= 1'b1;
      dim_q      <= '0;
      count_q    <= '0;
      exp_len_q  <= '0;
      ids_end_q  <= '0;
      asm_q      <= '0;
      perr_q     <= bvrp_pkg::ST_OK;
      bad_q      <= '0;
    end else if (accept_i) begin
      if (in_i.final_byte) begin
        // body done, start over
        cnt_q      <= '0;
        magic_ok_q <= 1'b1;
        dim_q      <= '0;
        count_q    <= '0;
        exp_len_q  <= '0;
        ids_end_q  <= '0;
        asm_q      <= '0;
        perr_q     <= bvrp_pkg::ST_OK;
        bad_q      <= '0;
      end else begin
        cnt_q      <= cnt_d;
        magic_ok_q <= magic_ok_d;
        dim_q      <= dim_d;
        count_q    <= count_d;
        exp_len_q  <= exp_len_d;
        ids_end_q  <= ids_end_d;
        asm_q      <= asm_d;
        perr_q     <= perr_d;
        bad_q      <= bad_d;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/bvrp_queue.sv
// Small queue of per-byte result entries between front and back end.
// Depends on bvrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bvrp_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire bvrp_pkg::entry_t  entry_i,
  input  wire logic              pop_i,
  output bvrp_pkg::entry_t       head_o,
  output logic                   full_o,
  output logic                   empty_o
);

  localparam int unsigned AW = $clog2(bvrp_pkg::QDEPTH);

  bvrp_pkg::entry_t mem_q [bvrp_pkg::QDEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   fill_q;

  assign full_o  = (fill_q == (AW + 1)'(bvrp_pkg::QDEPTH));
  assign empty_o = (fill_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + AW'(1);
      if (pop_i) rd_q <= rd_q + AW'(1);
      fill_q <= fill_q + (AW + 1)'(push_i) - (AW + 1)'(pop_i);
    end
  end

endmodule

`default_nettype wire

>>> rtl/bvrp_back.sv
// Back end: turns each queued entry into one or two result beats.
// Depends on bvrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bvrp_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bvrp_pkg::entry_t  head_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output bvrp_pkg::out_t         out_data_o
);

  logic sent_data_q;
  logic show_data;
  logic beat;

  assign show_data   = head_i.data_v && !sent_data_q;
  assign out_valid_o = !empty_i;
  assign beat        = out_valid_o && !out_stall_i;
  // data beat of a final byte leaves the entry for its status beat
  assign pop_o       = beat && (!show_data || !head_i.fin_v);

  always_comb begin
    out_data_o.record_count = head_i.record_count;
    if (show_data) begin
      out_data_o.kind       = head_i.kind;
      out_data_o.word       = head_i.word;
      out_data_o.position   = head_i.position;
      out_data_o.status     = bvrp_pkg::ST_OK;
      out_data_o.bad_record = '0;
      out_data_o.run_end    = !head_i.fin_v;
    end else begin
      out_data_o.kind       = bvrp_pkg::KIND_STATUS;
      out_data_o.word       = '0;
      out_data_o.position   = '0;
      out_data_o.status     = head_i.status;
      out_data_o.bad_record = head_i.bad_record;
      out_data_o.run_end    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_data_q <= 1'b0;
    end else if (pop_o) begin
      sent_data_q <= 1'b0;
    end else if (beat && show_data) begin
      sent_data_q <= 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bulk_vector_record_parser.sv
// Top level of the bulk vector record parser: config registers, front, queue, back.
// Depends on bvrp_pkg, bvrp_front, bvrp_queue, bvrp_back and the macros header.
//
//   channel | dir | handshake           | beat
//   in      | in  | in_valid_i/stall_o  | one body byte plus final flag
//   out     | out | out_valid_o/stall_i | one id, float word or status
//   cfg     | in  | cfg_valid_i/ready_o | register index and value
//
// One byte per clock while input is not stalled; the byte is parsed in the cycle it is accepted.
// A final byte that also completes a data word yields two beats, one per cycle while output is not stalled.
// A four-entry queue parts the sides; input stalls only while it is full.
// Reset returns the parser to the start of a body; registers take defaults.
`timescale 1ns / 1ps
`default_nettype none

`include "bulk_vector_record_parser_macros.svh"

module bulk_vector_record_parser #(
  parameter int unsigned BATCH_CAP   = bvrp_pkg::BATCH_CAP_DEF,
  parameter int unsigned LENGTH_BITS = bvrp_pkg::LENGTH_BITS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire bvrp_pkg::in_t   in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output bvrp_pkg::out_t       out_data_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [1:0]      cfg_index_i,
  input  wire logic [63:0]     cfg_data_i
);

  bvrp_pkg::cfg_t   cfg_q;
  bvrp_pkg::entry_t entry, head;
  logic push, pop, full, empty, accept;
  logic out_status, data_clean, final_acc;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign accept      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_dim <= bvrp_pkg::EXP_DIM_RST;
      cfg_q.batch_limit  <= bvrp_pkg::BATCH_LIM_RST;
      cfg_q.reserved_id  <= bvrp_pkg::RSV_ID_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (bvrp_pkg::cfg_reg_e'(cfg_index_i))
        bvrp_pkg::CFG_EXPECTED_DIM: cfg_q.expected_dim <= cfg_data_i[15:0];
        bvrp_pkg::CFG_BATCH_LIMIT:  cfg_q.batch_limit  <= cfg_data_i[20:0];
        bvrp_pkg::CFG_RESERVED_ID:  cfg_q.reserved_id  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bvrp_front #(
    .BATCH_CAP  (BATCH_CAP),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .accept_i(accept),
    .in_i    (in_data_i),
    .push_o  (push),
    .entry_o (entry)
  );

  bvrp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .pop_i  (pop),
    .head_o (head),
    .full_o (full),
    .empty_o(empty)
  );

  bvrp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  assign out_status = (out_data_o.kind == bvrp_pkg::KIND_STATUS);
  assign data_clean = (out_data_o.status == bvrp_pkg::ST_OK) && (out_data_o.bad_record == '0);
  assign final_acc  = accept && in_data_i.final_byte;

  `BVRP_ASSERT_IMP(a_status_ends_run, out_valid_o && out_status, out_data_o.run_end, "no run end")
  `BVRP_ASSERT_IMP(a_data_clean, out_valid_o && !out_status, data_clean, "data beat carries status")
  `BVRP_ASSERT_NXT(a_final_queued, final_acc, out_valid_o, "final byte left no result")

endmodule

`default_nettype wire

>>> verif/tb_bulk_vector_record_parser.sv
// Self-checking testbench for bulk_vector_record_parser: streams bulk bodies under
// random idling and backpressure and scores every output beat against a local parser model.
// Depends on bvrp_pkg and the RTL of the parser.
`timescale 1ns / 1ps

module tb_bulk_vector_record_parser;

  localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;
  localparam logic [39:0] CNT_SAT = 40'hFF_FFFF_FFFF;
  localparam int unsigned MAX_RECORDS = 1048576;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid;
  logic           in_stall_o;
  bvrp_pkg::in_t  in_data;
  logic           out_valid_o;
  logic           out_stall;
  bvrp_pkg::out_t out_data_o;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready_o;
  logic [1:0]     cfg_index = '0;
  logic [63:0]    cfg_data = '0;

  bulk_vector_record_parser i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // register copies
  logic [15:0] m_dim = bvrp_pkg::EXP_DIM_RST;
  logic [20:0] m_limit = bvrp_pkg::BATCH_LIM_RST;
  logic [63:0] m_rsv = bvrp_pkg::RSV_ID_RST;

  // parser state copies
  logic [39:0] p_count;
  logic        p_tag_ok;
  logic [31:0] p_hdim;
  logic [63:0] p_hcount;
  logic [39:0] p_exp_len;
  logic [63:0] p_asm;
  logic [2:0]  p_err;
  logic [19:0] p_bad;

  bvrp_pkg::in_t  byte_q[$];
  bvrp_pkg::out_t parsed_q[$];
  logic [7:0] body[$];
  int unsigned bytes_in = 0;
  int unsigned errors = 0;

  task automatic clear_parser();
    p_count = '0;
    p_tag_ok = 1'b1;
    p_hdim = '0;
    p_hcount = '0;
    p_exp_len = '0;
    p_asm = '0;
    p_err = bvrp_pkg::ST_OK;
    p_bad = '0;
  endtask

  task automatic parse_byte(bvrp_pkg::in_t it);
    logic [39:0] pos;
    logic [63:0] len;
    logic [63:0] ids_end;
    logic [63:0] idx;
    logic        hdr_err;
    int unsigned k;
    bvrp_pkg::out_t    r;
    bvrp_pkg::status_e st;
    pos = p_count;
    hdr_err = (p_err == bvrp_pkg::ST_BAD_HDR) || (p_err == bvrp_pkg::ST_DIM) ||
              (p_err == bvrp_pkg::ST_LIMIT);
    if (pos < 4) begin
      if (it.byte_value != bvrp_pkg::TAG_BYTES[pos]) p_tag_ok = 1'b0;
    end else if (pos < 8) begin
      p_hdim[8*(pos-4) +: 8] = it.byte_value;
    end else if (pos < bvrp_pkg::HEADER_BYTES) begin
      p_hcount[8*(pos-8) +: 8] = it.byte_value;
    end
    if (pos == bvrp_pkg::HEADER_BYTES - 1) begin
      if (!p_tag_ok) p_err = bvrp_pkg::ST_BAD_HDR;
      else if (p_hdim != {16'd0, m_dim}) p_err = bvrp_pkg::ST_DIM;
      else if (p_hcount > {43'd0, m_limit} || p_hcount > MAX_RECORDS) p_err = bvrp_pkg::ST_LIMIT;
      else begin
        len = bvrp_pkg::HEADER_BYTES + p_hcount * 8 + p_hcount * {32'd0, p_hdim} * 4;
        p_exp_len = (len > {24'd0, CNT_SAT}) ? CNT_SAT : len[39:0];
      end
    end else if (pos >= bvrp_pkg::HEADER_BYTES && !hdr_err) begin
      ids_end = bvrp_pkg::HEADER_BYTES + p_hcount * 8;
      if (pos >= p_exp_len) begin
        p_err = bvrp_pkg::ST_LENGTH;
      end else if (p_err == bvrp_pkg::ST_OK) begin
        if ({24'd0, pos} < ids_end) begin
          k = pos[2:0];
          if (k == 0) p_asm = '0;
          p_asm[8*k +: 8] = it.byte_value;
          if (k == 7) begin
            idx = ({24'd0, pos} - bvrp_pkg::HEADER_BYTES) >> 3;
            if (p_asm == m_rsv) begin
              p_err = bvrp_pkg::ST_RESERVED;
              p_bad = idx[19:0];
            end else begin
              r = '0;
              r.kind = bvrp_pkg::KIND_ID;
              r.word = p_asm;
              r.position = idx[35:0];
              r.record_count = p_hcount;
              r.run_end = !it.final_byte;
              parsed_q = {parsed_q, r};
            end
          end
        end else begin
          k = pos[1:0];
          if (k == 0) p_asm = '0;
          p_asm[8*k +: 8] = it.byte_value;
          if (k == 3) begin
            idx = ({24'd0, pos} - ids_end) >> 2;
            r = '0;
            r.kind = bvrp_pkg::KIND_FLOAT;
            r.word = {32'd0, p_asm[31:0]};
            r.position = idx[35:0];
            r.record_count = p_hcount;
            r.run_end = !it.final_byte;
            parsed_q = {parsed_q, r};
          end
        end
      end
    end
    if (p_count < CNT_SAT) p_count = p_count + 1;
    if (it.final_byte) begin
      len = {24'd0, pos} + 1;
      if (pos < bvrp_pkg::HEADER_BYTES - 1) st = bvrp_pkg::ST_BAD_HDR;
      else if (p_err == bvrp_pkg::ST_BAD_HDR || p_err == bvrp_pkg::ST_DIM ||
               p_err == bvrp_pkg::ST_LIMIT) st = bvrp_pkg::status_e'(p_err);
      else if (len >= {24'd0, CNT_SAT} || {24'd0, p_exp_len} != len) st = bvrp_pkg::ST_LENGTH;
      else if (p_err == bvrp_pkg::ST_RESERVED) st = bvrp_pkg::ST_RESERVED;
      else st = bvrp_pkg::ST_OK;
      r = '0;
      r.kind = bvrp_pkg::KIND_STATUS;
      r.status = st;
      r.bad_record = (st == bvrp_pkg::ST_RESERVED) ? p_bad : '0;
      r.record_count = p_hcount;
      r.run_end = 1'b1;
      parsed_q = {parsed_q, r};
      clear_parser();
    end
  endtask

  initial clear_parser();

  // input beats are fed to the parser model as they are accepted
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && !in_stall_o) begin
      parse_byte(in_data);
      bytes_in++;
    end
  end

  // driver: bursts and gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else if (!in_valid || !in_stall_o) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        in_data <= byte_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(40, 1);
          gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall modes that change every so often, plus one long hold-off
  int unsigned mode_left = 0;
  int unsigned stall_mode = 0;
  int unsigned hold_left = 0;
  bit          held_once = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!held_once && bytes_in >= 300 && byte_q.size() >= 100) begin
      // plenty of bytes still pending, so the queue fills behind the hold
      held_once = 1'b1;
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(64, 8);
        stall_mode = $urandom_range(3, 0);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(1, 0) == 0);
        2: out_stall <= ($urandom_range(9, 0) != 0);
        default: out_stall <= ($urandom_range(4, 0) == 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk_i) begin
    bvrp_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (parsed_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: kind=%0d word=%h pos=%0d st=%0d", out_data_o.kind,
                   out_data_o.word, out_data_o.position, out_data_o.status);
      end else begin
        want = parsed_q.pop_front();
        if (out_data_o.kind !== want.kind || out_data_o.word !== want.word ||
            out_data_o.position !== want.position || out_data_o.status !== want.status ||
            out_data_o.bad_record !== want.bad_record ||
            out_data_o.record_count !== want.record_count ||
            out_data_o.run_end !== want.run_end) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: exp kind=%0d word=%h pos=%0d st=%0d bad=%0d cnt=%h end=%0b",
                     want.kind, want.word, want.position, want.status, want.bad_record,
                     want.record_count, want.run_end);
            $display("          got kind=%0d word=%h pos=%0d st=%0d bad=%0d cnt=%h end=%0b",
                     out_data_o.kind, out_data_o.word, out_data_o.position,
                     out_data_o.status, out_data_o.bad_record,
                     out_data_o.record_count, out_data_o.run_end);
          end
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      bvrp_pkg::CFG_EXPECTED_DIM: m_dim = val[15:0];
      bvrp_pkg::CFG_BATCH_LIMIT:  m_limit = val[20:0];
      bvrp_pkg::CFG_RESERVED_ID:  m_rsv = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (byte_q.size() != 0 || in_valid || parsed_q.size() != 0);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // header plus n_rec ids and n_val float words into body
  task automatic build_body(logic [31:0] dim, logic [63:0] cnt, int unsigned n_rec,
                            int unsigned n_val);
    logic [63:0] id;
    body.delete();
    for (int i = 0; i < 4; i++) body = {body, bvrp_pkg::TAG_BYTES[i]};
    for (int i = 0; i < 4; i++) body = {body, dim[8*i +: 8]};
    for (int i = 0; i < 8; i++) body = {body, cnt[8*i +: 8]};
    for (int r = 0; r < n_rec; r++) begin
      case ($urandom_range(5, 0))
        0: id = m_rsv + 1;
        1: id = m_rsv - 1;
        default: id = rand64();
      endcase
      if (id == m_rsv) id[0] = ~id[0];
      for (int i = 0; i < 8; i++) body = {body, id[8*i +: 8]};
    end
    for (int v = 0; v < n_val * 4; v++) body = {body, 8'($urandom)};
  endtask

  task automatic place_reserved(int unsigned rec);
    for (int i = 0; i < 8; i++) body[bvrp_pkg::HEADER_BYTES + rec*8 + i] = m_rsv[8*i +: 8];
  endtask

  task automatic commit_body();
    bvrp_pkg::in_t it;
    foreach (body[i]) begin
      it.byte_value = body[i];
      it.final_byte = (i == body.size() - 1);
      byte_q = {byte_q, it};
    end
    body.delete();
  endtask

  task automatic good_body(int unsigned c);
    build_body({16'd0, m_dim}, c, c, c * m_dim);
  endtask

  task automatic random_body();
    int unsigned c;
    int unsigned sel;
    c = $urandom_range(3, 0);
    if (c > m_limit) c = m_limit;
    sel = $urandom_range(19, 0);
    if (sel < 10) begin
      good_body(c);
    end else if (sel < 12) begin
      good_body(c);
      repeat ($urandom_range(6, 1)) body = {body, 8'($urandom)};
    end else if (sel < 14) begin
      good_body(c);
      repeat ($urandom_range(body.size() - 1, 1)) void'(body.pop_back());
    end else if (sel == 14 && c > 0) begin
      good_body(c);
      place_reserved($urandom_range(c - 1, 0));
    end else if (sel == 15) begin
      good_body(c);
      body[$urandom_range(3, 0)] ^= 8'(1 << $urandom_range(7, 0));
    end else if (sel == 16) begin
      build_body({16'd0, m_dim} ^ (32'd1 << $urandom_range(31, 0)), c, c, c * m_dim);
    end else if (sel == 17) begin
      build_body({16'd0, m_dim},
                 ($urandom_range(1, 0) == 0) ? 64'(m_limit) + $urandom_range(3, 1)
                                              : rand64(), 1, 1);
    end else if (sel == 18) begin
      repeat ($urandom_range(15, 1)) body = {body, 8'($urandom)};
    end else begin
      repeat ($urandom_range(40, 1)) body = {body, 8'($urandom)};
    end
    commit_body();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // defaults: dim 1, limit 1024, reserved all ones
    body = {body, bvrp_pkg::TAG_BYTES[0]};
    commit_body();
    good_body(0);
    commit_body();
    good_body(2);
    commit_body();
    good_body(2);
    place_reserved(1);
    commit_body();
    good_body(1);
    body[2] = 8'h00;
    commit_body();
    wait_idle();

    write_reg(bvrp_pkg::CFG_EXPECTED_DIM, 64'd65535);
    write_reg(bvrp_pkg::CFG_BATCH_LIMIT, 64'd0);
    write_reg(bvrp_pkg::CFG_RESERVED_ID, 64'd0);
    good_body(0);
    commit_body();
    build_body(32'd65535, 64'd1, 1, 1);
    commit_body();
    build_body(32'hFFFF_FFFF, 64'd0, 0, 0);
    commit_body();
    wait_idle();

    write_reg(bvrp_pkg::CFG_EXPECTED_DIM, 64'd2);
    write_reg(bvrp_pkg::CFG_BATCH_LIMIT, 64'd1048575);
    write_reg(bvrp_pkg::CFG_RESERVED_ID, rand64());
    build_body(32'd2, 64'd1048576, 1, 2);
    commit_body();
    build_body(32'd2, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
    commit_body();
    good_body(3);
    place_reserved(0);
    commit_body();
    wait_idle();

    write_reg(CFG_UNUSED_IDX, rand64());
    write_reg(bvrp_pkg::CFG_BATCH_LIMIT, 64'd1048576);
    build_body(32'd2, 64'd1048577, 0, 0);
    commit_body();
    good_body(2);
    commit_body();
    wait_idle();

    while (bytes_in + byte_q.size() < 650) begin
      write_reg(bvrp_pkg::CFG_EXPECTED_DIM, $urandom_range(4, 1));
      write_reg(bvrp_pkg::CFG_BATCH_LIMIT, $urandom_range(6, 0));
      write_reg(bvrp_pkg::CFG_RESERVED_ID, ($urandom_range(1, 0) == 0) ? rand64() : 64'd0);
      repeat (6) random_body();
      wait_idle();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/bvrp_pkg.sv
rtl/bvrp_front.sv
rtl/bvrp_queue.sv
rtl/bvrp_back.sv
rtl/bulk_vector_record_parser.sv
verif/tb_bulk_vector_record_parser.sv
